@@ rtl/core/rlcp_pkg.sv @@
`default_nettype none

package rlcp_pkg;

   // field widths
   localparam int unsigned ChWidth     = 8;
   localparam int unsigned CountWidth  = 15;
   localparam int unsigned NumWidth    = 16;
   localparam int unsigned DigitsWidth = 4;
   localparam int unsigned StatusWidth = 4;
   localparam int unsigned CmdWidth    = 3;
   localparam int unsigned AddrWidth   = 3;
   localparam int unsigned DataWidth   = 16;

   typedef logic [ChWidth-1:0]     ch_type;
   typedef logic [CountWidth-1:0]  count_type;
   typedef logic [NumWidth-1:0]    num_type;
   typedef logic [DigitsWidth-1:0] digits_type;
   typedef logic [StatusWidth-1:0] status_type;
   typedef logic [CmdWidth-1:0]    cmd_type;
   typedef logic [AddrWidth-1:0]   csr_addr_type;
   typedef logic [DataWidth-1:0]   csr_data_type;
   typedef logic [1:0]             target_type;

   // register indexes
   localparam csr_addr_type CSR_RELAY_COUNT = 3'd0;
   localparam csr_addr_type CSR_LED_COUNT   = 3'd1;
   localparam csr_addr_type CSR_COLOR_COUNT = 3'd2;
   localparam csr_addr_type CSR_UNSET_VALUE = 3'd3;
   localparam csr_addr_type CSR_MAX_DIGITS  = 3'd4;

   // register reset values
   localparam count_type  RESET_RELAY_COUNT = 15'd8;
   localparam count_type  RESET_LED_COUNT   = 15'd8;
   localparam count_type  RESET_COLOR_COUNT = 15'd8;
   localparam num_type    RESET_UNSET_VALUE = 16'hFFFF;
   localparam digits_type RESET_MAX_DIGITS  = 4'd5;

   // status codes
   localparam status_type ST_PASS          = 4'd0;
   localparam status_type ST_NOT_LETTER    = 4'd1;
   localparam status_type ST_SECOND_CMD    = 4'd2;
   localparam status_type ST_BAD_NUMBER    = 4'd3;
   localparam status_type ST_UNKNOWN       = 4'd4;
   localparam status_type ST_NO_COMMAND    = 4'd5;
   localparam status_type ST_MISSING_INDEX = 4'd6;
   localparam status_type ST_INDEX_RANGE   = 4'd7;
   localparam status_type ST_VALUE_RANGE   = 4'd8;

   // command codes
   localparam cmd_type CMD_TEST         = 3'd0;
   localparam cmd_type CMD_TIME         = 3'd1;
   localparam cmd_type CMD_RELAY_SET    = 3'd2;
   localparam cmd_type CMD_RELAY_TOGGLE = 3'd3;
   localparam cmd_type CMD_LED          = 3'd4;
   localparam cmd_type CMD_NONE         = 3'd7;

   // number targets
   localparam target_type TGT_NUMBER = 2'd0;
   localparam target_type TGT_INDEX  = 2'd1;
   localparam target_type TGT_VALUE  = 2'd2;

   // characters
   localparam ch_type CH_NUL   = 8'h00;
   localparam ch_type CH_PLUS  = 8'h2B;
   localparam ch_type CH_MINUS = 8'h2D;
   localparam ch_type CH_ZERO  = 8'h30;
   localparam ch_type CH_NINE  = 8'h39;
   localparam ch_type CH_UP_A  = 8'h41;
   localparam ch_type CH_UP_L  = 8'h4C;
   localparam ch_type CH_UP_R  = 8'h52;
   localparam ch_type CH_UP_T  = 8'h54;
   localparam ch_type CH_UP_X  = 8'h58;
   localparam ch_type CH_UP_Z  = 8'h5A;
   localparam ch_type CH_LO_A  = 8'h61;
   localparam ch_type CH_LO_I  = 8'h69;
   localparam ch_type CH_LO_J  = 8'h6A;
   localparam ch_type CH_LO_Z  = 8'h7A;

   typedef enum logic [3:0] {
      PH_LETTER = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_SKIP   = 4'b1000
   } phase_type;

   typedef struct packed {
      count_type  relay_count;
      count_type  led_count;
      count_type  color_count;
      num_type    unset_value;
      digits_type max_digits;
   } cfg_type;

   typedef struct packed {
      status_type status;
      cmd_type    command;
      num_type    index;
      num_type    value;
      logic       value_given;
      num_type    number;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/rlcp_req_if.sv @@
`default_nettype none

interface rlcp_req_if;
   logic             valid;
   logic             ready;
   rlcp_pkg::ch_type ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rlcp_rsp_if.sv @@
`default_nettype none

interface rlcp_rsp_if;
   logic                 valid;
   logic                 ready;
   rlcp_pkg::status_type status;
   rlcp_pkg::cmd_type    command;
   rlcp_pkg::num_type    index;
   rlcp_pkg::num_type    value;
   logic                 value_given;
   rlcp_pkg::num_type    number;

   modport source (output valid, output status, output command, output index,
                   output value, output value_given, output number, input ready);
   modport sink (input valid, input status, input command, input index,
                 input value, input value_given, input number, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rlcp_csr_if.sv @@
`default_nettype none

interface rlcp_csr_if;
   logic                   valid;
   logic                   ready;
   rlcp_pkg::csr_addr_type addr;
   rlcp_pkg::csr_data_type wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rlcp_csr.sv @@
`default_nettype none

module rlcp_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  rlcp_pkg::csr_addr_type wr_addr,
   input  rlcp_pkg::csr_data_type wr_data,
   output rlcp_pkg::cfg_type      cfg
);
   import rlcp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_addr)
            CSR_RELAY_COUNT: cfg_in.relay_count = wr_data[CountWidth-1:0];
            CSR_LED_COUNT:   cfg_in.led_count   = wr_data[CountWidth-1:0];
            CSR_COLOR_COUNT: cfg_in.color_count = wr_data[CountWidth-1:0];
            CSR_UNSET_VALUE: cfg_in.unset_value = wr_data[NumWidth-1:0];
            CSR_MAX_DIGITS:  cfg_in.max_digits  = wr_data[DigitsWidth-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.relay_count <= RESET_RELAY_COUNT;
         cfg_ff.led_count   <= RESET_LED_COUNT;
         cfg_ff.color_count <= RESET_COLOR_COUNT;
         cfg_ff.unset_value <= RESET_UNSET_VALUE;
         cfg_ff.max_digits  <= RESET_MAX_DIGITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/rlcp_parse.sv @@
`default_nettype none

module rlcp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  rlcp_pkg::ch_type     ch,
   input  rlcp_pkg::cfg_type    cfg,
   output logic                 emit,
   output rlcp_pkg::result_type result
);
   import rlcp_pkg::*;

   phase_type  phase_ff, phase_in;
   target_type target_ff, target_in;
   num_type    acc_ff, acc_in;
   digits_type dcnt_ff, dcnt_in;
   logic       neg_ff, neg_in;
   cmd_type    cmd_ff, cmd_in;
   num_type    idx_ff, idx_in;
   num_type    val_ff, val_in;
   num_type    last_ff, last_in;
   status_type err_ff, err_in;

   logic       is_digit;
   logic       is_letter;
   logic       is_arg;
   logic [3:0] digit;
   num_type    signed_num;
   status_type status;

   always_comb begin
      phase_in   = phase_ff;
      target_in  = target_ff;
      acc_in     = acc_ff;
      dcnt_in    = dcnt_ff;
      neg_in     = neg_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      last_in    = last_ff;
      err_in     = err_ff;
      emit       = 1'b0;
      result     = '0;
      status     = ST_PASS;
      is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
      is_arg     = (ch >= CH_LO_A) && (ch < CH_LO_Z);
      is_letter  = !((ch < CH_UP_A) || (ch > CH_LO_Z) || ((ch > CH_UP_Z) && (ch < CH_LO_A)));
      digit      = (dcnt_ff < cfg.max_digits) ? ch[3:0] : 4'd0;
      signed_num = neg_ff ? 16'(16'd0 - acc_ff) : acc_ff;

      // number stage: a digit or first sign is consumed, else the number ends or fails
      if ((phase_ff == PH_SIGN) || (phase_ff == PH_DIGITS)) begin
         if (is_digit) begin
            acc_in    = 16'({acc_ff[12:0], 3'b000} + {acc_ff[14:0], 1'b0}
                           + {12'd0, digit});
            dcnt_in   = (dcnt_ff == 4'd15) ? dcnt_ff : 4'(dcnt_ff + 4'd1);
            phase_in  = PH_DIGITS;
         end else if ((phase_ff == PH_SIGN) && ((ch == CH_MINUS) || (ch == CH_PLUS))) begin
            neg_in    = (ch == CH_MINUS);
            phase_in  = PH_DIGITS;
         end else if (dcnt_ff == 4'd0) begin
            err_in    = ST_BAD_NUMBER;
            phase_in  = PH_SKIP;
         end else begin
            last_in   = signed_num;
            if (target_ff == TGT_INDEX) begin
               idx_in = signed_num;
            end else if (target_ff == TGT_VALUE) begin
               val_in = signed_num;
            end else begin
               cmd_in = CMD_TEST;
            end
            phase_in  = PH_LETTER;
         end
      end

      if (!(((phase_ff == PH_SIGN) || (phase_ff == PH_DIGITS))
            && (is_digit || ((phase_ff == PH_SIGN) && ((ch == CH_MINUS) || (ch == CH_PLUS))))))
      begin
         if (ch == CH_NUL) begin
            // line end: check the arguments
            if (err_in != ST_PASS) begin
               status = err_in;
            end else begin
               case (cmd_in)
                  CMD_TEST, CMD_TIME: status = ST_PASS;
                  CMD_RELAY_SET, CMD_RELAY_TOGGLE: begin
                     if (idx_in == cfg.unset_value) begin
                        status = ST_MISSING_INDEX;
                     end else if ($signed(idx_in) >= $signed({1'b0, cfg.relay_count})) begin
                        status = ST_INDEX_RANGE;
                     end else if ((cmd_in == CMD_RELAY_SET) && ($signed(val_in) > 16'sd1)
                                  && (val_in != cfg.unset_value)) begin
                        status = ST_VALUE_RANGE;
                     end else begin
                        status = ST_PASS;
                     end
                  end
                  CMD_LED: begin
                     if (idx_in == cfg.unset_value) begin
                        status = ST_MISSING_INDEX;
                     end else if ($signed(idx_in) >= $signed({1'b0, cfg.led_count})) begin
                        status = ST_INDEX_RANGE;
                     end else if ((val_in == cfg.unset_value)
                                  || ($signed(val_in) >= $signed({1'b0, cfg.color_count}))) begin
                        status = ST_VALUE_RANGE;
                     end else begin
                        status = ST_PASS;
                     end
                  end
                  default: status = ST_NO_COMMAND;
               endcase
            end
            emit               = 1'b1;
            result.status      = status;
            result.command     = (cmd_in == CMD_NONE) ? CMD_TEST : cmd_in;
            result.index       = idx_in;
            result.value       = val_in;
            result.value_given = (val_in != cfg.unset_value);
            result.number      = last_in;
            // fresh line
            phase_in  = PH_LETTER;
            target_in = TGT_NUMBER;
            acc_in    = '0;
            dcnt_in   = '0;
            neg_in    = 1'b0;
            cmd_in    = CMD_NONE;
            idx_in    = cfg.unset_value;
            val_in    = cfg.unset_value;
            last_in   = '0;
            err_in    = ST_PASS;
         end else if (phase_in == PH_LETTER) begin
            if (!is_letter) begin
               err_in   = ST_NOT_LETTER;
               phase_in = PH_SKIP;
            end else if (!is_arg && (cmd_in != CMD_NONE)) begin
               err_in   = ST_SECOND_CMD;
               phase_in = PH_SKIP;
            end else begin
               case (ch)
                  CH_UP_A, CH_LO_I, CH_LO_J: begin
                     target_in = (ch == CH_LO_I) ? TGT_INDEX :
                                 (ch == CH_LO_J) ? TGT_VALUE : TGT_NUMBER;
                     acc_in    = '0;
                     dcnt_in   = '0;
                     neg_in    = 1'b0;
                     phase_in  = PH_SIGN;
                  end
                  CH_UP_T: cmd_in = CMD_TIME;
                  CH_UP_R: cmd_in = CMD_RELAY_SET;
                  CH_UP_X: cmd_in = CMD_RELAY_TOGGLE;
                  CH_UP_L: cmd_in = CMD_LED;
                  default: begin
                     err_in   = ST_UNKNOWN;
                     phase_in = PH_SKIP;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LETTER;
         target_ff <= TGT_NUMBER;
         acc_ff    <= '0;
         dcnt_ff   <= '0;
         neg_ff    <= 1'b0;
         cmd_ff    <= CMD_NONE;
         idx_ff    <= RESET_UNSET_VALUE;
         val_ff    <= RESET_UNSET_VALUE;
         last_ff   <= '0;
         err_ff    <= ST_PASS;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         target_ff <= target_in;
         acc_ff    <= acc_in;
         dcnt_ff   <= dcnt_in;
         neg_ff    <= neg_in;
         cmd_ff    <= cmd_in;
         idx_ff    <= idx_in;
         val_ff    <= val_in;
         last_ff   <= last_in;
         err_ff    <= err_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/relay_led_command_parser_top.sv @@
// a line-end word sits in the input register; the parser step on it loads the result register
// throughput: one character word per cycle, sustained, while the result side keeps up
// while a result waits to be taken the parser holds and the input register takes one more word
// reset: synchronous, active high; clears the line state and loads register defaults
// no clearing pass is needed, the block takes words as soon as reset is released
`default_nettype none

module relay_led_command_parser_top (
   input logic        clock,
   input logic        reset,
   rlcp_req_if.sink   req_port,
   rlcp_rsp_if.source rsp_port,
   rlcp_csr_if.sink   csr_port
);
   import rlcp_pkg::*;

   // input register
   logic       in_valid_ff;
   ch_type     in_ch_ff;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   logic       step_go;
   logic       emit;
   result_type result;
   cfg_type    cfg;

   // the parser steps whenever a word is held and the result slot can take a result
   assign step_go = in_valid_ff && (!rsp_valid_ff || rsp_port.ready);

   // input stage frees up in the same cycle it hands its word on
   assign req_port.ready = !in_valid_ff || step_go;

   // register writes are always taken
   assign csr_port.ready = 1'b1;

   rlcp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_port.valid),
      .wr_addr (csr_port.addr),
      .wr_data (csr_port.wdata),
      .cfg     (cfg)
   );

   rlcp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_go),
      .ch      (in_ch_ff),
      .cfg     (cfg),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         in_valid_ff <= req_port.valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_ch_ff <= req_port.ch;
      end
   end

   // result slot: filled at line end, emptied when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      if (step_go && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_data_ff.status;
   assign rsp_port.command     = rsp_data_ff.command;
   assign rsp_port.index       = rsp_data_ff.index;
   assign rsp_port.value       = rsp_data_ff.value;
   assign rsp_port.value_given = rsp_data_ff.value_given;
   assign rsp_port.number      = rsp_data_ff.number;

`ifndef SYNTHESIS
   // a result only appears after the parser stepped on a line end
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_go && emit))
      else $error("result appeared without a line end");

   // a held word that cannot step stays put
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step_go) |=> (in_valid_ff && $stable(in_ch_ff)))
      else $error("stalled input word lost");

   // status code stays within the defined set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status <= ST_VALUE_RANGE))
      else $error("status code out of range");

   // a passing line always carries a real command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == ST_PASS)) |-> (rsp_data_ff.command <= CMD_LED))
      else $error("passing line with bad command code");
`endif

endmodule

`default_nettype wire

@@ bench/tb_relay_led_command_parser_top.sv @@
`timescale 1ns / 100ps

module tb_relay_led_command_parser_top;
   import rlcp_pkg::*;

   // run limit in clock cycles, far above the slowest legal run
   localparam int CycleLimit   = 500000;
   // receiver hold-off that backs the block up into its input
   localparam int HoldCycles   = 300;
   // characters of random lines per setting
   localparam int PhaseChars   = 375;
   // cycles allowed for words still inside the block
   localparam int DrainCycles  = 6;

   // predicts one result word per line end from the character stream
   class line_result_predictor;
      count_type  relay_count;
      count_type  led_count;
      count_type  color_count;
      num_type    unset_value;
      digits_type max_digits;

      phase_type  phase;
      target_type target;
      num_type    accum;
      digits_type digit_count;
      logic       negative;
      cmd_type    command;
      num_type    index_reg;
      num_type    value_reg;
      num_type    last_number;
      status_type error_code;

      result_type expected_lines[$];
      int         fail_count;

      function new();
         relay_count = RESET_RELAY_COUNT;
         led_count   = RESET_LED_COUNT;
         color_count = RESET_COLOR_COUNT;
         unset_value = RESET_UNSET_VALUE;
         max_digits  = RESET_MAX_DIGITS;
         fail_count  = 0;
         start_line();
      endfunction

      function void start_line();
         phase       = PH_LETTER;
         target      = TGT_NUMBER;
         accum       = '0;
         digit_count = '0;
         negative    = 1'b0;
         command     = CMD_NONE;
         index_reg   = unset_value;
         value_reg   = unset_value;
         last_number = '0;
         error_code  = ST_PASS;
      endfunction

      function void abort_line(status_type code);
         error_code = code;
         phase      = PH_SKIP;
      endfunction

      function void open_number(target_type t);
         target      = t;
         accum       = '0;
         digit_count = '0;
         negative    = 1'b0;
         phase       = PH_SIGN;
      endfunction

      function void close_number();
         num_type v;
         v = negative ? (16'd0 - accum) : accum;
         last_number = v;
         if (target == TGT_INDEX) index_reg = v;
         else if (target == TGT_VALUE) value_reg = v;
         else command = CMD_TEST;
         phase = PH_LETTER;
      endfunction

      function void take_letter(ch_type ch);
         logic arg_letter;
         arg_letter = (ch >= CH_LO_A) && (ch < CH_LO_Z);
         if (ch < CH_UP_A || ch > CH_LO_Z || (ch > CH_UP_Z && ch < CH_LO_A)) begin
            abort_line(ST_NOT_LETTER);
            return;
         end
         if (!arg_letter && command != CMD_NONE) begin
            abort_line(ST_SECOND_CMD);
            return;
         end
         case (ch)
            CH_UP_A: open_number(TGT_NUMBER);
            CH_UP_T: command = CMD_TIME;
            CH_UP_R: command = CMD_RELAY_SET;
            CH_UP_X: command = CMD_RELAY_TOGGLE;
            CH_UP_L: command = CMD_LED;
            CH_LO_I: open_number(TGT_INDEX);
            CH_LO_J: open_number(TGT_VALUE);
            default: abort_line(ST_UNKNOWN);
         endcase
      endfunction

      function status_type grade_line();
         int i;
         int j;
         i = $signed(index_reg);
         j = $signed(value_reg);
         if (error_code != ST_PASS) return error_code;
         case (command)
            CMD_TEST, CMD_TIME: return ST_PASS;
            CMD_RELAY_SET, CMD_RELAY_TOGGLE: begin
               if (index_reg == unset_value) return ST_MISSING_INDEX;
               if (i >= int'(relay_count)) return ST_INDEX_RANGE;
               if (command == CMD_RELAY_SET && j > 1 && value_reg != unset_value)
                  return ST_VALUE_RANGE;
               return ST_PASS;
            end
            CMD_LED: begin
               if (index_reg == unset_value) return ST_MISSING_INDEX;
               if (i >= int'(led_count)) return ST_INDEX_RANGE;
               if (value_reg == unset_value || j >= int'(color_count))
                  return ST_VALUE_RANGE;
               return ST_PASS;
            end
            default: return ST_NO_COMMAND;
         endcase
      endfunction

      function void set_reg(csr_addr_type addr, csr_data_type data);
         case (addr)
            CSR_RELAY_COUNT: relay_count = data[CountWidth-1:0];
            CSR_LED_COUNT:   led_count   = data[CountWidth-1:0];
            CSR_COLOR_COUNT: color_count = data[CountWidth-1:0];
            CSR_UNSET_VALUE: unset_value = data[NumWidth-1:0];
            CSR_MAX_DIGITS:  max_digits  = data[DigitsWidth-1:0];
            default: ;
         endcase
      endfunction

      function void note_char(ch_type ch);
         num_type    d;
         result_type res;
         if (phase == PH_SIGN || phase == PH_DIGITS) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
               d = (digit_count < max_digits) ? num_type'(ch - CH_ZERO) : '0;
               accum = accum * 16'd10 + d;
               if (digit_count < 4'd15) digit_count++;
               phase = PH_DIGITS;
               return;
            end
            if (phase == PH_SIGN && (ch == CH_MINUS || ch == CH_PLUS)) begin
               negative = (ch == CH_MINUS);
               phase    = PH_DIGITS;
               return;
            end
            if (digit_count == 0) abort_line(ST_BAD_NUMBER);
            else close_number();
            if (ch != CH_NUL && phase == PH_LETTER) begin
               take_letter(ch);
               return;
            end
         end
         if (ch == CH_NUL) begin
            res.status      = grade_line();
            res.command     = (command == CMD_NONE) ? CMD_TEST : command;
            res.index       = index_reg;
            res.value       = value_reg;
            res.value_given = (value_reg != unset_value);
            res.number      = last_number;
            expected_lines.push_back(res);
            start_line();
            return;
         end
         if (phase == PH_LETTER) take_letter(ch);
      endfunction

      function void report(string msg);
         fail_count++;
         if (fail_count <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void check_line(result_type act);
         result_type exp;
         if (expected_lines.size() == 0) begin
            report("result word with no line pending");
            return;
         end
         exp = expected_lines.pop_front();
         if (act !== exp)
            report($sformatf({"line result mismatch: expected st %0d cmd %0d idx %0d ",
                              "val %0d given %0b num %0d, got st %0d cmd %0d idx %0d ",
                              "val %0d given %0b num %0d"},
                             exp.status, exp.command, $signed(exp.index),
                             $signed(exp.value), exp.value_given, $signed(exp.number),
                             act.status, act.command, $signed(act.index),
                             $signed(act.value), act.value_given, $signed(act.number)));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rlcp_req_if req_if();
   rlcp_rsp_if rsp_if();
   rlcp_csr_if csr_if();

   relay_led_command_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   line_result_predictor pred;

   int     send_idle_pct = 0;
   int     rsp_idle_pct  = 0;
   logic   hold_request  = 1'b0;
   int     hold_left     = 0;
   int     cycle_count   = 0;
   int     chars_sent    = 0;
   ch_type line_buf[$];

   // free-running clock, 2 ns period
   always #1 clock = ~clock;

   // every block input at a known value from time zero
   initial begin
      req_if.valid  = 1'b0;
      req_if.ch     = CH_NUL;
      csr_if.valid  = 1'b0;
      csr_if.addr   = CSR_RELAY_COUNT;
      csr_if.wdata  = '0;
   end

   // run limit: a hang anywhere ends in a fail
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("relay_led_command_parser_top regression: fail");
         $finish;
      end
   end

   // accepted character words feed the predictor
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) pred.note_char(req_if.ch);
   end

   // accepted register writes update the predicted settings
   always @(posedge clock) begin
      if (!reset && csr_if.valid && csr_if.ready) pred.set_reg(csr_if.addr, csr_if.wdata);
   end

   // accepted result words are checked against the oldest pending line
   always @(posedge clock) begin
      result_type act;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         act.status      = rsp_if.status;
         act.command     = rsp_if.command;
         act.index       = rsp_if.index;
         act.value       = rsp_if.value;
         act.value_given = rsp_if.value_given;
         act.number      = rsp_if.number;
         pred.check_line(act);
      end
   end

   // receiver: random stalls, plus a long hold-off when asked for
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // offer one character word, with random gaps before it; entered at a falling edge
   task automatic send_char(ch_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.ch    = c;
      do @(posedge clock); while (!req_if.ready);
      chars_sent++;
      @(negedge clock);
   endtask

   // send the line buffer followed by the terminating zero byte
   task automatic send_line();
      foreach (line_buf[k]) send_char(line_buf[k]);
      send_char(CH_NUL);
      line_buf.delete();
   endtask

   function automatic void put_text(string s);
      for (int k = 0; k < s.len(); k++) line_buf.push_back(ch_type'(s[k]));
   endfunction

   task automatic send_text(string s);
      put_text(s);
      send_line();
   endtask

   // signed decimal with an occasional plus sign or leading zero
   function automatic void put_number(int v);
      int mag;
      mag = (v < 0) ? -v : v;
      if (v < 0) line_buf.push_back(CH_MINUS);
      else if ($urandom_range(5) == 0) line_buf.push_back(CH_PLUS);
      if ($urandom_range(7) == 0) line_buf.push_back(CH_ZERO);
      put_text($sformatf("%0d", mag));
   endfunction

   // argument values clustered on the range edges and the sentinel
   function automatic int arg_value(int bound);
      case ($urandom_range(8))
         0: return 0;
         1: return 1;
         2: return bound - 1;
         3: return bound;
         4: return bound + 1;
         5: return int'($signed(pred.unset_value));
         6: return -int'($urandom_range(1, 40));
         7: return int'($urandom_range(0, 65535)) - 32768;
         default: return int'($urandom_range(0, bound + 2));
      endcase
   endfunction

   // one command letter with up to three arguments, in random order
   function automatic void put_command_line();
      ch_type letters[5];
      ch_type cmd_ch;
      int     nargs;
      int     cmd_slot;
      int     idx_bound;
      int     val_bound;
      logic   is_index;
      letters = '{CH_UP_A, CH_UP_T, CH_UP_R, CH_UP_X, CH_UP_L};
      cmd_ch  = letters[$urandom_range(4)];
      nargs   = $urandom_range(3);
      cmd_slot = ($urandom_range(99) < 80 || nargs == 0) ? 0 : 1;
      idx_bound = (cmd_ch == CH_UP_L) ? int'(pred.led_count) : int'(pred.relay_count);
      val_bound = (cmd_ch == CH_UP_L) ? int'(pred.color_count) :
                  (cmd_ch == CH_UP_R) ? 2 : 8;
      for (int k = 0; k <= nargs; k++) begin
         if (k == cmd_slot) begin
            line_buf.push_back(cmd_ch);
            if (cmd_ch == CH_UP_A)
               put_number(($urandom_range(1) == 0) ? int'($urandom_range(0, 200)) :
                          int'($urandom_range(0, 99999)) - 50000);
         end
         if (k < nargs) begin
            is_index = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(2) == 0);
            line_buf.push_back(is_index ? CH_LO_I : CH_LO_J);
            put_number(arg_value(is_index ? idx_bound : val_bound));
         end
      end
   endfunction

   // mostly well-formed lines, some broken ones, some empty ones and some raw noise
   task automatic send_random_line();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 78) begin
         put_command_line();
      end else if (pick < 92) begin
         put_command_line();
         case ($urandom_range(4))
            0: line_buf.insert($urandom_range(line_buf.size()),
                               ch_type'($urandom_range(1, 255)));
            1: line_buf.push_back(($urandom_range(1) == 0) ? CH_LO_I : CH_LO_J);
            2: begin
               line_buf.push_back(CH_LO_J);
               line_buf.push_back(($urandom_range(1) == 0) ? CH_MINUS : CH_PLUS);
            end
            3: line_buf.push_back(($urandom_range(1) == 0) ? CH_UP_T : CH_LO_Z);
            default: line_buf.push_back(ch_type'($urandom_range(CH_LO_A, CH_LO_Z)));
         endcase
      end else if (pick < 95) begin
         // empty line
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) line_buf.push_back(ch_type'($urandom_range(1, 255)));
      end
      send_line();
   endtask

   task automatic send_random_lines(int count);
      int stop_at;
      stop_at = chars_sent + count;
      while (chars_sent < stop_at) send_random_line();
      req_if.valid = 1'b0;
   endtask

   task automatic write_csr(csr_addr_type addr, csr_data_type data);
      csr_if.valid = 1'b1;
      csr_if.addr  = addr;
      csr_if.wdata = data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // wait for every pending line, then let the pipeline empty
   task automatic wait_drained();
      while (pred.expected_lines.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic apply_setting(count_type relays, count_type leds, count_type colors,
                                num_type unset, digits_type digits);
      write_csr(CSR_RELAY_COUNT, csr_data_type'(relays));
      write_csr(CSR_LED_COUNT,   csr_data_type'(leds));
      write_csr(CSR_COLOR_COUNT, csr_data_type'(colors));
      write_csr(CSR_UNSET_VALUE, csr_data_type'(unset));
      write_csr(CSR_MAX_DIGITS,  csr_data_type'(digits));
   endtask

   initial begin
      pred = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: sender mostly busy, receiver mostly stalled
      send_idle_pct = 11;
      rsp_idle_pct  = 78;

      // directed lines at the reset settings
      send_text("A123");
      send_text("T");
      send_text("Ri3j1");
      send_text("Xi7");
      send_text("Li2j7");
      send_text("Li8j0");         // led index at the bound
      send_text("Li2j8");         // color at the bound
      send_text("Ri-5j1");        // negative index passes
      send_text("Ri2j-3");        // negative relay value passes
      send_text("Ri2j2");
      send_text("R");             // missing index
      send_text("");              // nothing on the line
      send_text("i3");            // argument without a command
      send_text("Tz");            // z counts as a command letter
      send_text("z");
      send_text("Tb");            // unused argument letter
      send_text("@[`{#");         // characters just outside the letter ranges
      send_text("TR");
      send_text("A");             // number cut by line end with no digit
      send_text("A-");
      send_text("A+99999999");    // digits beyond the limit count as zeros
      send_text("A-32768");
      send_text("Ri-1");          // index equal to the unset sentinel
      send_text("Ri3i4j0j1");     // repeated arguments, the last one wins
      send_text("Ai");
      send_text("A12T");
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      send_line();
      send_random_lines(PhaseChars);
      wait_drained();

      // lowest settings, sentinel zero
      apply_setting(15'd1, 15'd1, 15'd1, 16'h0000, 4'd1);
      send_idle_pct = 78;
      rsp_idle_pct  = 11;
      send_random_lines(PhaseChars);
      wait_drained();

      // highest counts, most negative sentinel, no idling, long receiver hold-off
      apply_setting(15'd32767, 15'd32767, 15'd32767, 16'h8000, 4'd10);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      send_random_lines(PhaseChars);
      wait_drained();

      // small random counts, most positive sentinel
      apply_setting(count_type'($urandom_range(2, 20)), count_type'($urandom_range(2, 20)),
                    count_type'($urandom_range(2, 20)), 16'h7FFF,
                    digits_type'($urandom_range(2, 9)));
      send_random_lines(PhaseChars);
      wait_drained();

      // lines still pending here count as failures
      if (pred.expected_lines.size() != 0) pred.report("lines left without a result");
      if (pred.fail_count == 0) begin
         $display("relay_led_command_parser_top regression: pass");
      end else begin
         $display("relay_led_command_parser_top regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/rlcp_pkg.sv
rtl/core/rlcp_req_if.sv
rtl/core/rlcp_rsp_if.sv
rtl/core/rlcp_csr_if.sv
rtl/core/rlcp_csr.sv
rtl/core/rlcp_parse.sv
rtl/core/relay_led_command_parser_top.sv
bench/tb_relay_led_command_parser_top.sv
